>>> src/sorted_key_front_encoder_unit_assert.svh
// Assertion macros for the sorted key front encoder.
// Used by the port checker; no other dependencies.
`ifndef SORTED_KEY_FRONT_ENCODER_UNIT_ASSERT_SVH
`define SORTED_KEY_FRONT_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SKFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skfe check failed");

// next-cycle implication, disabled during reset
`define SKFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skfe check failed");

`endif

>>> src/skfe_pkg.sv
// Shared types and constants for the sorted key front encoder.
// No dependencies.
`default_nettype none

package skfe_pkg;

    localparam int CPL_W     = 9;
    localparam int OPQ_DEPTH = 4;
    localparam int OPQ_AW    = 2;
    localparam int PADDR_W   = 3;

    localparam logic KIND_SUFFIX = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    localparam logic REG_CPL = 1'b0;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       last_byte;
        logic       block_start;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [7:0]  suffix_byte;
        logic [15:0] prefix_len_code;
        logic [15:0] length_code;
        logic        too_long;
        logic        last;
    } t_out;

    typedef struct packed {
        logic             en;
        logic [CPL_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [7:0]  key_byte;
        logic        cand;
        logic        elig;
        logic        eq;
        logic        last_byte;
        logic        rec;
        logic        too_long;
        logic [15:0] length_code;
    } t_op;

endpackage

`default_nettype wire

>>> src/skfe_front.sv
// Front end: position tracking, key store and per-byte classification.
// Depends on skfe_pkg.
`default_nettype none

module skfe_front import skfe_pkg::*; #(
    parameter int MAX_KEY_LEN = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg_wr          i_cfg_wr,
    output logic [CPL_W-1:0]      o_cpl,
    input  wire logic             i_push,
    input  wire t_in              i_item,
    output logic                  o_full,
    output logic                  o_op_vld,
    output t_op                   o_op,
    input  wire logic             i_op_full
);

    localparam int AW = $clog2(MAX_KEY_LEN);
    localparam logic [15:0] KEY_LIM = 16'(MAX_KEY_LEN);

    logic [CPL_W-1:0] r_cpl;
    logic [15:0]      r_pos, n_pos;
    logic             r_priming, n_priming;
    logic             r_ovf, n_ovf;
    logic [15:0]      r_prev_len, n_prev_len;
    logic             r_stg_vld, n_stg_vld;
    t_op              r_stg_op, n_stg_op;
    logic [7:0]       r_mem [MAX_KEY_LEN];
    logic [7:0]       r_rd;

    logic             w_acc, w_prim, w_coded, w_in_store, w_ovf, w_wr;
    logic [15:0]      w_j, w_len, w_cpl16;
    logic [16:0]      w_count, w_len17, w_cpl17;
    logic [AW-1:0]    w_addr;

    assign o_full   = r_stg_vld & i_op_full;
    assign w_acc    = i_push & ~o_full;
    assign o_cpl    = r_cpl;
    assign o_op_vld = r_stg_vld;

    always_comb begin
        o_op    = r_stg_op;
        o_op.eq = (r_rd == r_stg_op.key_byte);
    end

    always_comb begin
        w_cpl16    = {7'b0, r_cpl};
        w_cpl17    = {8'b0, r_cpl};
        w_prim     = r_priming | i_item.block_start;
        w_coded    = (r_pos >= w_cpl16);
        w_j        = r_pos - w_cpl16;
        w_in_store = (w_j < KEY_LIM);
        w_ovf      = r_ovf | (w_coded & ~w_in_store);
        w_wr       = w_coded & w_in_store;
        w_addr     = w_j[AW-1:0];
        w_count    = {1'b0, r_pos} + 17'd1;
        w_len17    = (w_count > w_cpl17) ? (w_count - w_cpl17) : 17'd0;
        w_len      = (w_len17 > 17'h0FFFF) ? 16'hFFFF : w_len17[15:0];

        n_stg_op.key_byte    = i_item.key_byte;
        n_stg_op.cand        = w_coded & ~w_prim;
        n_stg_op.elig        = w_in_store & (w_j < r_prev_len);
        n_stg_op.eq          = 1'b0;
        n_stg_op.last_byte   = i_item.last_byte;
        n_stg_op.rec         = i_item.last_byte & ~w_prim;
        n_stg_op.too_long    = w_ovf;
        n_stg_op.length_code = w_len ^ r_prev_len;

        n_pos      = r_pos;
        n_priming  = r_priming;
        n_ovf      = r_ovf;
        n_prev_len = r_prev_len;
        if (w_acc) begin
            if (i_item.last_byte) begin
                n_pos      = '0;
                n_priming  = 1'b0;
                n_ovf      = 1'b0;
                n_prev_len = w_len;
            end else begin
                n_pos      = (r_pos != 16'hFFFF) ? (r_pos + 16'd1) : r_pos;
                n_priming  = w_prim;
                n_ovf      = w_ovf;
            end
        end

        if (w_acc) begin
            n_stg_vld = 1'b1;
        end else if (~i_op_full) begin
            n_stg_vld = 1'b0;
        end else begin
            n_stg_vld = r_stg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpl      <= '0;
            r_pos      <= '0;
            r_priming  <= 1'b1;
            r_ovf      <= 1'b0;
            r_prev_len <= '0;
            r_stg_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr.en) begin
                r_cpl <= i_cfg_wr.data;
            end
            r_pos      <= n_pos;
            r_priming  <= n_priming;
            r_ovf      <= n_ovf;
            r_prev_len <= n_prev_len;
            r_stg_vld  <= n_stg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_stg_op <= n_stg_op;
        end
    end

    // read old contents, then store this byte at the same place
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd <= r_mem[w_addr];
            if (w_wr) begin
                r_mem[w_addr] <= i_item.key_byte;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/skfe_opq.sv
// Short queue of classified byte operations between front and back ends.
// Depends on skfe_pkg.
`default_nettype none

module skfe_opq import skfe_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    output logic      o_full,
    input  wire logic i_pop,
    output t_op       o_op,
    output logic      o_empty
);

    t_op                r_ent [OPQ_DEPTH];
    logic [OPQ_AW-1:0]  r_wp, r_rp;
    logic [OPQ_AW:0]    r_cnt;
    logic               w_wr, w_rd;

    assign o_full  = (r_cnt == (OPQ_AW+1)'(OPQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push & ~o_full;
    assign w_rd    = i_pop & ~o_empty;
    assign o_op    = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_ent[r_wp] <= i_op;
        end
    end

endmodule

`default_nettype wire

>>> src/skfe_back.sv
// Back end: prefix match tracking and result generation into the output register.
// Depends on skfe_pkg.
`default_nettype none

module skfe_back import skfe_pkg::*; #(
    parameter int MAX_KEY_LEN = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_op  i_op,
    input  wire logic i_op_empty,
    output logic      o_op_pop,
    output logic      o_empty,
    output t_out      o_item,
    input  wire logic i_pop
);

    localparam int SW = $clog2(MAX_KEY_LEN + 1);

    logic          r_sm;
    logic [SW-1:0] r_shared, r_prev_pfx;
    logic          r_phase;
    logic          r_out_vld;
    t_out          r_out, n_out;

    logic          w_match, w_inc, w_sfx, w_rec, w_emit, w_retire, w_free, w_fire;
    logic [SW-1:0] w_shared_nxt;

    assign o_empty = ~r_out_vld;
    assign o_item  = r_out;

    always_comb begin
        w_match      = r_sm & i_op.elig & i_op.eq;
        w_inc        = ~r_phase & i_op.cand & w_match;
        w_sfx        = ~r_phase & i_op.cand & ~w_match;
        w_rec        = i_op.rec & ~w_sfx;
        w_emit       = w_sfx | w_rec;
        w_retire     = ~(w_sfx & i_op.rec);
        w_free       = ~r_out_vld | i_pop;
        w_fire       = ~i_op_empty & (~w_emit | w_free);
        o_op_pop     = w_fire & w_retire;
        w_shared_nxt = r_shared + SW'(w_inc);

        n_out.too_long = i_op.too_long;
        if (w_sfx) begin
            n_out.kind            = KIND_SUFFIX;
            n_out.suffix_byte     = i_op.key_byte;
            n_out.prefix_len_code = '0;
            n_out.length_code     = '0;
            n_out.last            = ~i_op.rec;
        end else begin
            n_out.kind            = KIND_RECORD;
            n_out.suffix_byte     = '0;
            n_out.prefix_len_code = 16'(w_shared_nxt ^ r_prev_pfx);
            n_out.length_code     = i_op.length_code;
            n_out.last            = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm       <= 1'b1;
            r_shared   <= '0;
            r_prev_pfx <= '0;
            r_phase    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (w_fire) begin
                if (w_retire && i_op.last_byte) begin
                    r_sm       <= 1'b1;
                    r_shared   <= '0;
                    r_prev_pfx <= i_op.rec ? w_shared_nxt : '0;
                end else begin
                    if (w_sfx) begin
                        r_sm <= 1'b0;
                    end
                    r_shared <= w_shared_nxt;
                end
                r_phase <= ~w_retire;
            end
            if (w_fire && w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> src/sorted_key_front_encoder_unit.sv
// Top level of the sorted key front encoder: config port, front, queue, back.
// Depends on skfe_pkg, skfe_front, skfe_opq, skfe_back.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+--------------------------
//   key in   | in        | push / full         | i_item (t_in)
//   results  | out       | empty / pop         | o_item (t_out)
//   config   | in        | psel/penable/pready | paddr, pwdata, prdata
//
// One key byte is accepted per cycle unless full is high.
// A last byte that yields both a suffix byte and a record is popped once both are sent.
// The key store is one read/write port of MAX_KEY_LEN bytes, read and written per byte.
// Reset clears all control state; the key store is not cleared.
// Front and back stall independently through a four-entry operation queue.
`default_nettype none

module sorted_key_front_encoder_unit import skfe_pkg::*; #(
    parameter int MAX_KEY_LEN = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    input  wire t_in                i_item,
    output logic                    full,
    output logic                    empty,
    output t_out                    o_item,
    input  wire logic               pop,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_cfg_wr          w_cfg_wr;
    logic [CPL_W-1:0] w_cpl;
    logic             w_stg_vld, w_opq_full, w_opq_empty, w_opq_pop;
    t_op              w_stg_op, w_opq_op;

    assign pready      = 1'b1;
    assign w_cfg_wr.en = psel & penable & pwrite & pready & (paddr[2] == REG_CPL);
    assign w_cfg_wr.data = pwdata[CPL_W-1:0];
    assign prdata      = (paddr[2] == REG_CPL) ? {23'b0, w_cpl} : 32'b0;

    skfe_front #(
        .MAX_KEY_LEN (MAX_KEY_LEN)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_wr  (w_cfg_wr),
        .o_cpl     (w_cpl),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .o_op_vld  (w_stg_vld),
        .o_op      (w_stg_op),
        .i_op_full (w_opq_full)
    );

    skfe_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_stg_vld),
        .i_op    (w_stg_op),
        .o_full  (w_opq_full),
        .i_pop   (w_opq_pop),
        .o_op    (w_opq_op),
        .o_empty (w_opq_empty)
    );

    skfe_back #(
        .MAX_KEY_LEN (MAX_KEY_LEN)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_opq_op),
        .i_op_empty (w_opq_empty),
        .o_op_pop   (w_opq_pop),
        .o_empty    (empty),
        .o_item     (o_item),
        .i_pop      (pop)
    );

endmodule

`default_nettype wire

>>> src/skfe_checker.sv
// Port-level checker for the sorted key front encoder, bound to the top level.
// Depends on skfe_pkg and sorted_key_front_encoder_unit_assert.svh.
`default_nettype none

`include "sorted_key_front_encoder_unit_assert.svh"

module skfe_checker import skfe_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic empty,
    input wire logic pop,
    input wire t_out o_item
);

    `SKFE_ASSERT_NOW(a_rec_last, i_clk, i_rst_n, !empty && o_item.kind == KIND_RECORD, o_item.last)

    `SKFE_ASSERT_NOW(a_sfx_codes, i_clk, i_rst_n, !empty && o_item.kind == KIND_SUFFIX, o_item.prefix_len_code == 16'd0 && o_item.length_code == 16'd0)

    `SKFE_ASSERT_NOW(a_rec_byte, i_clk, i_rst_n, !empty && o_item.kind == KIND_RECORD, o_item.suffix_byte == 8'd0)

    `SKFE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_item))

endmodule

bind sorted_key_front_encoder_unit skfe_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_item  (o_item)
);

`default_nettype wire

>>> verif/front_code_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted key front encoder: predicts the coded results of every
// accepted key byte and compares each result transfer field by field.
// Depends on skfe_pkg; watches the key, result and register channels.

module front_code_checker import skfe_pkg::*; #(
    parameter int MAX_KEY_LEN = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  t_in                i_item,
    input  logic               pop,
    input  logic               empty,
    input  t_out               o_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    output int                 o_mismatches,
    output int                 o_pending
);

    localparam logic [PADDR_W-1:0] CPL_ADDR = PADDR_W'(4 * REG_CPL);
    localparam int COUNT_MAX  = 65535;

    logic [CPL_W-1:0] drop_len;
    logic [7:0]       key_store [MAX_KEY_LEN];
    int               prev_len;
    int               prev_shared;
    int               byte_pos;
    int               shared_len;
    bit               matching;
    bit               priming;
    bit               overflow;
    t_out             coded_q [$];
    int               fails = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            fails++;
        end
    endfunction

    task automatic code_byte(input t_in it);
        int   pos;
        int   j;
        int   len;
        bit   stored;
        bit   hit;
        t_out res;
        t_out fresh [$];
        pos = byte_pos;
        if (it.block_start)
            priming = 1'b1;
        if (pos >= int'(drop_len)) begin
            j = pos - int'(drop_len);
            stored = j < MAX_KEY_LEN;
            if (!stored)
                overflow = 1'b1;
            if (!priming) begin
                hit = matching && stored && j < prev_len &&
                      key_store[stored ? j : 0] == it.key_byte;
                if (hit) begin
                    shared_len++;
                end else begin
                    matching = 1'b0;
                    res = '0;
                    res.kind = KIND_SUFFIX;
                    res.suffix_byte = it.key_byte;
                    res.too_long = overflow;
                    fresh.insert(fresh.size(), res);
                end
            end
            if (stored)
                key_store[j] = it.key_byte;
        end
        if (byte_pos < COUNT_MAX)
            byte_pos++;
        if (it.last_byte) begin
            len = (pos + 1 > int'(drop_len)) ? pos + 1 - int'(drop_len) : 0;
            if (len > COUNT_MAX)
                len = COUNT_MAX;
            if (priming) begin
                prev_shared = 0;
                priming = 1'b0;
            end else begin
                res = '0;
                res.kind = KIND_RECORD;
                res.prefix_len_code = 16'(shared_len ^ prev_shared);
                res.length_code = 16'(len ^ prev_len);
                res.too_long = overflow;
                fresh.insert(fresh.size(), res);
                prev_shared = shared_len;
            end
            prev_len   = len;
            byte_pos   = 0;
            shared_len = 0;
            matching   = 1'b1;
            overflow   = 1'b0;
        end
        if (fresh.size() > 0)
            fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[k])
            coded_q.insert(coded_q.size(), fresh[k]);
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            drop_len    = '0;
            prev_len    = 0;
            prev_shared = 0;
            byte_pos    = 0;
            shared_len  = 0;
            matching    = 1'b1;
            priming     = 1'b1;
            overflow    = 1'b0;
            coded_q.delete();
        end else begin
            if (pop && !empty) begin
                if (coded_q.size() == 0) begin
                    $display("%0t ns: result mismatch, expected none, actual 0x%0h",
                             $time, o_item);
                    fails++;
                end else begin
                    want = coded_q.pop_front();
                    check_field("kind", 32'(want.kind), 32'(o_item.kind));
                    check_field("suffix_byte", 32'(want.suffix_byte),
                                32'(o_item.suffix_byte));
                    check_field("prefix_len_code", 32'(want.prefix_len_code),
                                32'(o_item.prefix_len_code));
                    check_field("length_code", 32'(want.length_code),
                                32'(o_item.length_code));
                    check_field("too_long", 32'(want.too_long), 32'(o_item.too_long));
                    check_field("last", 32'(want.last), 32'(o_item.last));
                end
            end
            if (push && !full)
                code_byte(i_item);
            if (psel && penable && pready && paddr == CPL_ADDR) begin
                if (pwrite)
                    drop_len = pwdata[CPL_W-1:0];
                else
                    check_field("prdata", 32'(drop_len), prdata);
            end
        end
        o_pending    <= coded_q.size();
        o_mismatches <= fails;
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Top of the sorted key front encoder testbench: clock, reset, key stimulus,
// register programming and result draining. Depends on skfe_pkg, the encoder
// and front_code_checker, which predicts and compares.

module testbench;
    import skfe_pkg::*;

    localparam int MAX_KEY_LEN   = 256;
    localparam logic [PADDR_W-1:0] CPL_ADDR = PADDR_W'(4 * REG_CPL);
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 240;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    t_in                i_item;
    logic               full;
    logic               empty;
    t_out               o_item;
    logic               pop;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 mismatches;
    int                 pending;

    int                 tx_idle_pct;
    int                 rx_idle_pct;
    bit                 hold_rx;
    int                 sent;
    logic [7:0]         prior_key [$];

    sorted_key_front_encoder_unit #(.MAX_KEY_LEN(MAX_KEY_LEN)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_item  (i_item),
        .full    (full),
        .empty   (empty),
        .o_item  (o_item),
        .pop     (pop),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    front_code_checker #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_front_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_item       (i_item),
        .pop          (pop),
        .empty        (empty),
        .o_item       (o_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // drain results; hold off once for a long stretch when asked
    initial begin
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                hold_rx = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            pop <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_byte(input t_in it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sent++;
    endtask

    // copy the first keep bytes of the previous key, then fill
    task automatic send_key(input int len, input int keep, input int blk_at,
                            input int fill_byte);
        logic [7:0] fresh [$];
        logic [7:0] b;
        t_in        it;
        for (int i = 0; i < len; i++) begin
            if (i < keep && i < prior_key.size())
                b = prior_key[i];
            else if (fill_byte >= 0)
                b = 8'(fill_byte);
            else
                b = 8'($urandom);
            fresh.insert(fresh.size(), b);
            it.key_byte    = b;
            it.last_byte   = (i == len - 1);
            it.block_start = (i == blk_at);
            send_byte(it);
        end
        prior_key = fresh;
    endtask

    task automatic settle();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the register, then read it back
    task automatic program_drop_len(input int unsigned value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CPL_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_keys(input int count);
        int  goal;
        int  len;
        int  keep;
        int  blk_at;
        int  pick;
        t_in noise;
        goal = sent + count;
        while (sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                if ($urandom_range(0, 3) == 0)
                    program_drop_len($urandom_range(0, 1) ? 256 : 255);
                else
                    program_drop_len($urandom_range(0, 6));
            end else if (pick < 9) begin
                noise.key_byte    = 8'($urandom);
                noise.last_byte   = 1'($urandom);
                noise.block_start = ($urandom_range(0, 7) == 0);
                send_byte(noise);
            end else begin
                len    = ($urandom_range(0, 99) < 3) ? $urandom_range(250, 300)
                                                     : $urandom_range(1, 24);
                keep   = ($urandom_range(0, 9) < 7) ? $urandom_range(0, len) : 0;
                blk_at = ($urandom_range(0, 99) < 6) ? $urandom_range(0, len - 1) : -1;
                send_key(len, keep, blk_at, -1);
            end
        end
    endtask

    initial begin : stimulus
        t_in it;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_item      <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        tx_idle_pct = 29;
        rx_idle_pct = 85;
        hold_rx     = 1'b0;
        sent        = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // prime with a key that fills the whole store, then repeat it
        send_key(MAX_KEY_LEN + 1, 0, 0, -1);
        send_key(MAX_KEY_LEN + 1, MAX_KEY_LEN + 1, -1, -1);
        send_key(1, 0, -1, 8'h00);
        send_key(1, 0, -1, 8'hFF);
        send_key(3, 0, -1, 8'hFF);
        send_key(3, 3, -1, -1);
        send_key(6, 1, 3, -1);
        send_key(4, 2, -1, -1);

        program_drop_len(3);
        send_key(2, 0, -1, -1);
        send_key(6, 0, -1, -1);
        send_key(7, 5, -1, -1);

        // change the dropped prefix in mid key
        for (int i = 0; i < 4; i++) begin
            it.key_byte    = 8'($urandom);
            it.last_byte   = 1'b0;
            it.block_start = 1'b0;
            send_byte(it);
        end
        program_drop_len(1);
        for (int i = 0; i < 3; i++) begin
            it.key_byte    = 8'($urandom);
            it.last_byte   = (i == 2);
            it.block_start = 1'b0;
            send_byte(it);
        end

        program_drop_len(256);
        send_key(5, 0, -1, -1);
        send_key(258, 0, -1, -1);
        send_key(258, 257, -1, -1);
        program_drop_len(0);

        random_keys(RANDOM_ITEMS / 3);

        settle();
        tx_idle_pct = 85;
        rx_idle_pct = 29;
        random_keys(RANDOM_ITEMS / 3);

        settle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_rx     = 1'b1;
        random_keys(RANDOM_ITEMS / 3);

        settle();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
